// ===== rtl/lattice_hop_event_selector_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the lattice hop event selector
// Implication checks, same cycle and next cycle, dropped when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef LATTICE_HOP_EVENT_SELECTOR_TOP_ASSERT_SVH
`define LATTICE_HOP_EVENT_SELECTOR_TOP_ASSERT_SVH

`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define LHES_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("lhes assertion failed");
// antecedent implies consequent in the next cycle
`define LHES_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("lhes assertion failed");
`else
`define LHES_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define LHES_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/lhes_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhes_pkg
// Shared widths, codes and the divider request type.
// ----------------------------------------------------------------------------
package lhes_pkg;

	localparam int FRAC_BITS = 8;
	localparam int RATE_W    = 40;   // hop rate, 32.8
	localparam int TOTAL_W   = 49;   // total rate, 41.8
	localparam int TIME_W    = 64;
	localparam int DVD_W     = 41;   // dividend and quotient of the divider

	localparam logic [2:0] CMD_CLEAR = 3'd0;
	localparam logic [2:0] CMD_ADJ   = 3'd1;
	localparam logic [2:0] CMD_DEG   = 3'd2;
	localparam logic [2:0] CMD_PLACE = 3'd3;
	localparam logic [2:0] CMD_STEP  = 3'd4;

	localparam logic [1:0] STATUS_DONE   = 2'd0;
	localparam logic [1:0] STATUS_NOHOP  = 2'd1;
	localparam logic [1:0] STATUS_REJECT = 2'd2;

	typedef struct packed {
		logic                 start;
		logic [DVD_W-1:0]     dividend;
		logic [TOTAL_W-1:0]   divisor;
	} lhes_div_req_t;

endpackage

// ===== rtl/lhes_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhes_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lhes_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr,
	input  logic [W-1:0]                   wdata,
	input  logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr,
	output logic [W-1:0]                   rdata
);

	logic [W-1:0] mem [D];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/lhes_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhes_divider
// Restoring divider, one quotient bit per cycle, 41-bit dividend.
// ----------------------------------------------------------------------------
module lhes_divider
	import lhes_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  lhes_div_req_t     req,
	output logic [DVD_W-1:0]  quotient,
	output logic              done
);

	logic [TOTAL_W:0]   rem_q;
	logic [DVD_W-1:0]   dvd_q;
	logic [TOTAL_W-1:0] dvs_q;
	logic [5:0]         cnt_q;
	logic               run_q;
	logic [TOTAL_W:0]   rem_sh;
	logic               fits;

	// shift in the next dividend bit and trial subtract
	assign rem_sh = {rem_q[TOTAL_W-1:0], dvd_q[DVD_W-1]};
	assign fits   = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(DVD_W - 1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	// datapath: quotient bits replace dividend bits from the bottom
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (run_q) begin
			rem_q <= fits ? rem_sh - {1'b0, dvs_q} : rem_sh;
			dvd_q <= {dvd_q[DVD_W-2:0], fits};
		end
	end

	assign quotient = dvd_q;

endmodule

// ===== rtl/lattice_hop_event_selector_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lattice_hop_event_selector_top
// Kinetic Monte Carlo hop step over a lattice held in block memories.
//
//   channel   handshake               payload
//   command   start / busy            command, site_index .. random_fraction
//   result    done (one-cycle strobe) status .. elapsed_time
//   config    cfg_wr_en               cfg_wr_data (particle_count)
//
// After reset the occupancy and degree memories are swept with busy high,
// and clear lattice sweeps the occupancy memory again. A step walks the
// particle slots and reads every neighbor slot of each placed particle; the
// hop of each free slot, while the hop list has room, goes through the shared
// serial divider. A step with hops then scans the listed hops and takes the
// time increment from the divider before the move.
// Results cannot be held off; one command is worked at a time.
// ----------------------------------------------------------------------------
`include "lattice_hop_event_selector_top_assert.svh"

module lattice_hop_event_selector_top
	import lhes_pkg::*;
#(
	parameter int SITE_COUNT     = 1024,
	parameter int MAX_DEGREE     = 8,
	parameter int PARTICLE_SLOTS = 64,
	parameter int EVENT_DEPTH    = 512
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  logic [2:0]   command,
	input  logic [9:0]   site_index,
	input  logic [2:0]   slot_index,
	input  logic [9:0]   neighbor_index,
	input  logic [31:0]  path_rate,
	input  logic [3:0]   count_value,
	input  logic [5:0]   particle_index,
	input  logic [31:0]  random_fraction,
	input  logic         cfg_wr_en,
	input  logic [6:0]   cfg_wr_data,
	output logic         done,
	output logic [1:0]   status,
	output logic [5:0]   moved_particle,
	output logic [9:0]   from_site,
	output logic [9:0]   to_site,
	output logic [9:0]   event_total,
	output logic [48:0]  total_rate,
	output logic [63:0]  elapsed_time
);

	localparam int SW  = SITE_COUNT > 1 ? $clog2(SITE_COUNT) : 1;
	localparam int AW  = $clog2(SITE_COUNT * MAX_DEGREE);
	localparam int DW  = $clog2(MAX_DEGREE + 1);
	localparam int JW  = MAX_DEGREE > 1 ? $clog2(MAX_DEGREE) : 1;
	localparam int PW  = PARTICLE_SLOTS > 1 ? $clog2(PARTICLE_SLOTS) : 1;
	localparam int PW1 = $clog2(PARTICLE_SLOTS + 1);
	localparam int HW  = EVENT_DEPTH > 1 ? $clog2(EVENT_DEPTH) : 1;
	localparam int EW  = $clog2(EVENT_DEPTH + 1);
	localparam int HOP_W = RATE_W + PW + SW;
	localparam int ACC_W = RATE_W + EW;

	localparam logic [4:0] ST_INIT   = 5'd0;
	localparam logic [4:0] ST_IDLE   = 5'd1;
	localparam logic [4:0] ST_DISP   = 5'd2;
	localparam logic [4:0] ST_CLR    = 5'd3;
	localparam logic [4:0] ST_PL_CHK = 5'd4;
	localparam logic [4:0] ST_PL_SET = 5'd5;
	localparam logic [4:0] ST_P_NEXT = 5'd6;
	localparam logic [4:0] ST_P_LOC  = 5'd7;
	localparam logic [4:0] ST_P_DEG  = 5'd8;
	localparam logic [4:0] ST_A_RD   = 5'd9;
	localparam logic [4:0] ST_A_OCC  = 5'd10;
	localparam logic [4:0] ST_A_CHK  = 5'd11;
	localparam logic [4:0] ST_H_NEXT = 5'd12;
	localparam logic [4:0] ST_H_DIV  = 5'd13;
	localparam logic [4:0] ST_SEL    = 5'd14;
	localparam logic [4:0] ST_MUL2   = 5'd15;
	localparam logic [4:0] ST_MUL3   = 5'd16;
	localparam logic [4:0] ST_SC_RD  = 5'd17;
	localparam logic [4:0] ST_SC_CHK = 5'd18;
	localparam logic [4:0] ST_TDIV   = 5'd19;
	localparam logic [4:0] ST_MV_FR  = 5'd20;
	localparam logic [4:0] ST_MV_SET = 5'd21;
	localparam logic [4:0] ST_FIN    = 5'd22;

	logic [4:0] state_q;

	// latched command item
	logic [2:0]  cmd_q;
	logic [9:0]  site_q;
	logic [2:0]  slot_q;
	logic [9:0]  nb_q;
	logic [31:0] rate_q;
	logic [3:0]  cnt_q;
	logic [5:0]  pidx_q;
	logic [31:0] rnd_q;

	logic [6:0]                pc_q;
	logic [PARTICLE_SLOTS-1:0] placed_q;
	logic [SW-1:0]             clr_q;
	logic [TIME_W-1:0]         clock_q;

	// step walk
	logic [PW1-1:0]     p_q;
	logic [SW-1:0]      s_q;
	logic [DW-1:0]      d_q;
	logic [DW-1:0]      j_q;
	logic [DW-1:0]      nfree_q;
	logic [SW-1:0]      slot_tgt_q  [MAX_DEGREE];
	logic [31:0]        slot_rate_q [MAX_DEGREE];
	logic [MAX_DEGREE-1:0] slot_free_q;
	logic               tgt_ok_q;
	logic [EW-1:0]      events_q;
	logic [TOTAL_W-1:0] total_q;

	// selection
	logic [63:0]        prod_lo_s1;
	logic [TOTAL_W:0]   prod_hi_s2;
	logic [TOTAL_W-1:0] target_q;
	logic [ACC_W-1:0]   acc_q;
	logic [EW-1:0]      i_q;
	logic [PW-1:0]      mp_q;
	logic [SW-1:0]      to_q;
	logic [SW-1:0]      from_q;

	// memory ports
	logic          occ_we, occ_wd, occ_rd;
	logic [SW-1:0] occ_wa, occ_ra;
	logic          deg_we;
	logic [DW-1:0] deg_wd, deg_rd;
	logic [SW-1:0] deg_wa, deg_ra;
	logic          adj_we;
	logic [AW-1:0] adj_wa, adj_ra;
	logic [41:0]   adj_rd;
	logic          loc_we;
	logic [PW-1:0] loc_wa, loc_ra;
	logic [SW-1:0] loc_wd, loc_rd;
	logic          hop_we;
	logic [HOP_W-1:0] hop_wd, hop_rd;

	lhes_div_req_t    div_req;
	logic [DVD_W-1:0] div_q;
	logic             div_done;

	logic accept;
	logic site_ok, slot_ok, pidx_ok;
	logic [PW1-1:0] n_part;
	logic [JW-1:0]  jx;
	logic [RATE_W-1:0] hop_rate;
	logic [PW-1:0]  hop_pid;
	logic [SW-1:0]  hop_tgt;
	logic [ACC_W-1:0] acc_n;
	logic [TOTAL_W:0] total_n;
	logic [TIME_W:0]  clock_n;
	logic a_free;

	assign busy   = state_q != ST_IDLE;
	assign accept = start && !busy;
	assign done   = state_q == ST_FIN;
	assign elapsed_time = clock_q;

	assign site_ok = 32'(site_q) < SITE_COUNT;
	assign slot_ok = 32'(slot_q) < MAX_DEGREE;
	assign pidx_ok = 32'(pidx_q) < PARTICLE_SLOTS;
	assign n_part  = (32'(pc_q) > PARTICLE_SLOTS) ? PW1'(PARTICLE_SLOTS) : PW1'(pc_q);
	assign jx      = j_q[JW-1:0];

	assign hop_rate = hop_rd[HOP_W-1 -: RATE_W];
	assign hop_pid  = hop_rd[SW +: PW];
	assign hop_tgt  = hop_rd[SW-1:0];
	assign acc_n    = acc_q + ACC_W'(hop_rate);
	assign total_n  = {1'b0, total_q} + (TOTAL_W+1)'(div_q[RATE_W-1:0]);
	assign clock_n  = {1'b0, clock_q} + (TIME_W+1)'(div_q);
	assign a_free   = tgt_ok_q && !occ_rd;

	// memory address and write selection
	always_comb begin
		occ_we = 1'b0; occ_wa = clr_q; occ_wd = 1'b0; occ_ra = SW'(site_q);
		deg_we = 1'b0; deg_wa = SW'(site_q); deg_ra = loc_rd;
		deg_wd = (32'(cnt_q) > MAX_DEGREE) ? DW'(MAX_DEGREE) : DW'(cnt_q);
		adj_we = 1'b0;
		adj_wa = AW'(32'(site_q) * MAX_DEGREE + 32'(slot_q));
		adj_ra = AW'(32'(s_q) * MAX_DEGREE + 32'(j_q));
		loc_we = 1'b0; loc_wa = PW'(pidx_q); loc_wd = SW'(site_q); loc_ra = PW'(pidx_q);
		hop_we = 1'b0;
		hop_wd = {div_q[RATE_W-1:0], PW'(p_q), slot_tgt_q[jx]};
		div_req.start    = 1'b0;
		div_req.dividend = DVD_W'({slot_rate_q[jx], 8'd0});
		div_req.divisor  = TOTAL_W'(nfree_q);
		case (state_q)
			ST_INIT: begin
				occ_we = 1'b1;
				deg_we = 1'b1; deg_wa = clr_q; deg_wd = '0;
			end
			ST_CLR: occ_we = 1'b1;
			ST_DISP: begin
				adj_we = (cmd_q == CMD_ADJ) && site_ok && slot_ok;
				deg_we = (cmd_q == CMD_DEG) && site_ok;
			end
			ST_PL_CHK: begin
				occ_we = !occ_rd && placed_q[PW'(pidx_q)];
				occ_wa = loc_rd;
			end
			ST_PL_SET: begin
				occ_we = 1'b1; occ_wa = SW'(site_q); occ_wd = 1'b1;
				loc_we = 1'b1;
			end
			ST_P_NEXT: loc_ra = PW'(p_q);
			ST_A_OCC:  occ_ra = SW'(adj_rd[41:32]);
			ST_H_NEXT: begin
				div_req.start = (j_q != d_q) && slot_free_q[jx] &&
					(32'(events_q) < EVENT_DEPTH);
			end
			ST_H_DIV: hop_we = div_done;
			ST_SC_CHK: begin
				loc_ra = hop_pid;
				div_req.start    = (acc_n > ACC_W'(target_q)) || (i_q == events_q - EW'(1));
				div_req.dividend = DVD_W'(1) << 40;
				div_req.divisor  = total_q;
			end
			ST_TDIV: loc_ra = mp_q;
			ST_MV_FR: begin
				occ_we = 1'b1; occ_wa = from_q;
			end
			ST_MV_SET: begin
				occ_we = 1'b1; occ_wa = to_q; occ_wd = 1'b1;
				loc_we = 1'b1; loc_wa = mp_q; loc_wd = to_q;
			end
			default: ;
		endcase
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_INIT;
			clr_q    <= '0;
			pc_q     <= 7'd50;
			placed_q <= '0;
			clock_q  <= '0;
		end else begin
			if (cfg_wr_en) begin
				pc_q <= cfg_wr_data;
			end
			case (state_q)
				ST_INIT: begin
					clr_q <= clr_q + SW'(1);
					if (32'(clr_q) == SITE_COUNT - 1) begin
						clr_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: if (accept) state_q <= ST_DISP;
				ST_DISP: begin
					case (cmd_q)
						CMD_CLEAR: begin
							placed_q <= '0;
							state_q  <= ST_CLR;
						end
						CMD_PLACE: state_q <= (site_ok && pidx_ok) ? ST_PL_CHK : ST_FIN;
						CMD_STEP:  state_q <= ST_P_NEXT;
						default:   state_q <= ST_FIN;
					endcase
				end
				ST_CLR: begin
					clr_q <= clr_q + SW'(1);
					if (32'(clr_q) == SITE_COUNT - 1) begin
						clr_q   <= '0;
						state_q <= ST_FIN;
					end
				end
				ST_PL_CHK: state_q <= occ_rd ? ST_FIN : ST_PL_SET;
				ST_PL_SET: begin
					placed_q[PW'(pidx_q)] <= 1'b1;
					state_q <= ST_FIN;
				end
				ST_P_NEXT: begin
					if (p_q >= n_part) state_q <= ST_SEL;
					else if (placed_q[PW'(p_q)]) state_q <= ST_P_LOC;
				end
				ST_P_LOC: state_q <= ST_P_DEG;
				ST_P_DEG: state_q <= (deg_rd == '0) ? ST_P_NEXT : ST_A_RD;
				ST_A_RD:  state_q <= ST_A_OCC;
				ST_A_OCC: state_q <= ST_A_CHK;
				ST_A_CHK: state_q <= (j_q == d_q - DW'(1)) ? ST_H_NEXT : ST_A_RD;
				ST_H_NEXT: begin
					if (j_q == d_q) state_q <= ST_P_NEXT;
					else if (div_req.start) state_q <= ST_H_DIV;
				end
				ST_H_DIV: if (div_done) state_q <= ST_H_NEXT;
				ST_SEL: begin
					state_q <= (events_q == '0 || total_q == '0) ? ST_FIN : ST_MUL2;
				end
				ST_MUL2:   state_q <= ST_MUL3;
				ST_MUL3:   state_q <= ST_SC_RD;
				ST_SC_RD:  state_q <= ST_SC_CHK;
				ST_SC_CHK: state_q <= div_req.start ? ST_TDIV : ST_SC_RD;
				ST_TDIV: begin
					if (div_done) begin
						clock_q <= clock_n[TIME_W] ? '1 : clock_n[TIME_W-1:0];
						state_q <= ST_MV_FR;
					end
				end
				ST_MV_FR:  state_q <= ST_MV_SET;
				ST_MV_SET: state_q <= ST_FIN;
				ST_FIN:    state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= command;
			site_q <= site_index;
			slot_q <= slot_index;
			nb_q   <= neighbor_index;
			rate_q <= path_rate;
			cnt_q  <= count_value;
			pidx_q <= particle_index;
			rnd_q  <= random_fraction;
		end
		case (state_q)
			ST_DISP: begin
				status         <= STATUS_DONE;
				moved_particle <= '0;
				from_site      <= '0;
				to_site        <= '0;
				event_total    <= '0;
				total_rate     <= '0;
				p_q      <= '0;
				events_q <= '0;
				total_q  <= '0;
			end
			ST_PL_CHK: if (occ_rd) status <= STATUS_REJECT;
			ST_P_NEXT: if (p_q < n_part && !placed_q[PW'(p_q)]) p_q <= p_q + PW1'(1);
			ST_P_LOC:  s_q <= loc_rd;
			ST_P_DEG: begin
				d_q     <= deg_rd;
				j_q     <= '0;
				nfree_q <= '0;
				if (deg_rd == '0) p_q <= p_q + PW1'(1);
			end
			ST_A_OCC: begin
				slot_tgt_q[jx]  <= SW'(adj_rd[41:32]);
				slot_rate_q[jx] <= adj_rd[31:0];
				tgt_ok_q        <= 32'(adj_rd[41:32]) < SITE_COUNT;
			end
			ST_A_CHK: begin
				slot_free_q[jx] <= a_free;
				nfree_q <= nfree_q + DW'(a_free);
				j_q     <= (j_q == d_q - DW'(1)) ? '0 : j_q + DW'(1);
			end
			ST_H_NEXT: begin
				if (j_q == d_q) p_q <= p_q + PW1'(1);
				else if (!div_req.start) j_q <= j_q + DW'(1);
			end
			ST_H_DIV: begin
				if (div_done) begin
					events_q <= events_q + EW'(1);
					total_q  <= total_n[TOTAL_W] ? '1 : total_n[TOTAL_W-1:0];
					j_q      <= j_q + DW'(1);
				end
			end
			ST_SEL: begin
				event_total <= (32'(events_q) > 1023) ? 10'd1023 : 10'(events_q);
				total_rate  <= total_q;
				if (events_q == '0 || total_q == '0) status <= STATUS_NOHOP;
				prod_lo_s1  <= 64'(rnd_q) * 64'(total_q[31:0]);
			end
			ST_MUL2: begin
				prod_hi_s2 <= (TOTAL_W+1)'(rnd_q) * (TOTAL_W+1)'(total_q[TOTAL_W-1:32]);
			end
			ST_MUL3: begin
				target_q <= TOTAL_W'(prod_hi_s2 + (TOTAL_W+1)'(prod_lo_s1[63:32]));
				acc_q    <= '0;
				i_q      <= '0;
			end
			ST_SC_CHK: begin
				acc_q <= acc_n;
				i_q   <= i_q + EW'(1);
				mp_q  <= hop_pid;
				to_q  <= hop_tgt;
			end
			ST_TDIV: from_q <= loc_rd;
			ST_MV_SET: begin
				moved_particle <= 6'(mp_q);
				from_site      <= 10'(from_q);
				to_site        <= 10'(to_q);
			end
			default: ;
		endcase
	end

	lhes_ram #(.W(1), .D(SITE_COUNT)) u_occ (
		.clk(clk), .we(occ_we), .waddr(occ_wa), .wdata(occ_wd),
		.raddr(occ_ra), .rdata(occ_rd)
	);

	lhes_ram #(.W(DW), .D(SITE_COUNT)) u_deg (
		.clk(clk), .we(deg_we), .waddr(deg_wa), .wdata(deg_wd),
		.raddr(deg_ra), .rdata(deg_rd)
	);

	lhes_ram #(.W(42), .D(SITE_COUNT * MAX_DEGREE)) u_adj (
		.clk(clk), .we(adj_we), .waddr(adj_wa), .wdata({nb_q, rate_q}),
		.raddr(adj_ra), .rdata(adj_rd)
	);

	lhes_ram #(.W(SW), .D(PARTICLE_SLOTS)) u_loc (
		.clk(clk), .we(loc_we), .waddr(loc_wa), .wdata(loc_wd),
		.raddr(loc_ra), .rdata(loc_rd)
	);

	lhes_ram #(.W(HOP_W), .D(EVENT_DEPTH)) u_hop (
		.clk(clk), .we(hop_we), .waddr(events_q[HW-1:0]), .wdata(hop_wd),
		.raddr(i_q[HW-1:0]), .rdata(hop_rd)
	);

	lhes_divider u_div (
		.clk(clk), .arst_n(arst_n), .req(div_req), .quotient(div_q), .done(div_done)
	);

	// checks
	`LHES_ASSERT_NXT(a_done_then_idle, clk, arst_n, done, !busy)
	`LHES_ASSERT_IMP(a_nohop_clean, clk, arst_n, done && status == STATUS_NOHOP,
		moved_particle == 6'd0 && from_site == 10'd0 && to_site == 10'd0)
	`LHES_ASSERT_IMP(a_events_bound, clk, arst_n, 1'b1, 32'(events_q) <= EVENT_DEPTH)
	`LHES_ASSERT_IMP(a_hop_room, clk, arst_n, state_q == ST_H_DIV && div_done,
		32'(events_q) < EVENT_DEPTH)

endmodule

// ===== sim/tb_lattice_hop_event_selector_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lattice_hop_event_selector_top
// Self-checking bench for the lattice hop selector. A behavioural lattice
// model predicts each command's result at acceptance. A monitor compares
// every done strobe against the oldest prediction. Directed corner cases come
// first, then random command streams under several particle_count settings.
// ----------------------------------------------------------------------------
module tb_lattice_hop_event_selector_top;
	import lhes_pkg::*;

	localparam int SITES  = 1024;
	localparam int DEGMAX = 8;
	localparam int SLOTS  = 64;
	localparam int DEPTH  = 512;

	typedef struct {
		bit [2:0]  cmd;
		bit [9:0]  site;
		bit [2:0]  slot;
		bit [9:0]  nb;
		bit [31:0] rate;
		bit [3:0]  cnt;
		bit [5:0]  pidx;
		bit [31:0] rnd;
	} hop_cmd_t;

	typedef struct {
		bit [1:0]  status;
		bit [5:0]  mover;
		bit [9:0]  src;
		bit [9:0]  dst;
		bit [9:0]  events;
		bit [48:0] total;
		bit [63:0] elapsed;
	} hop_res_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  command;
	logic [9:0]  site_index;
	logic [2:0]  slot_index;
	logic [9:0]  neighbor_index;
	logic [31:0] path_rate;
	logic [3:0]  count_value;
	logic [5:0]  particle_index;
	logic [31:0] random_fraction;
	logic        cfg_wr_en;
	logic [6:0]  cfg_wr_data;
	logic        done;
	logic [1:0]  status;
	logic [5:0]  moved_particle;
	logic [9:0]  from_site;
	logic [9:0]  to_site;
	logic [9:0]  event_total;
	logic [48:0] total_rate;
	logic [63:0] elapsed_time;

	// lattice model state
	bit        site_taken[SITES];
	bit [3:0]  site_degree[SITES];
	bit [9:0]  link_site[SITES*DEGMAX];
	bit [31:0] link_rate[SITES*DEGMAX];
	bit        link_loaded[SITES*DEGMAX];
	bit [9:0]  part_site[SLOTS];
	bit        part_on[SLOTS];
	bit [39:0] hop_rate[DEPTH];
	bit [5:0]  hop_part[DEPTH];
	bit [9:0]  hop_dst[DEPTH];
	bit [63:0] sim_clock;
	bit [6:0]  active_parts;

	hop_res_t  pending_results[$];
	int        mismatches;
	bit        idle_gaps;

	lattice_hop_event_selector_top i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .site_index(site_index), .slot_index(slot_index),
		.neighbor_index(neighbor_index), .path_rate(path_rate),
		.count_value(count_value), .particle_index(particle_index),
		.random_fraction(random_fraction), .cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data), .done(done), .status(status),
		.moved_particle(moved_particle), .from_site(from_site), .to_site(to_site),
		.event_total(event_total), .total_rate(total_rate),
		.elapsed_time(elapsed_time)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit link_free(int idx);
		return !site_taken[link_site[idx]];
	endfunction

	// one kinetic Monte Carlo hop over the modelled lattice
	function automatic hop_res_t predict_hop(bit [31:0] rnd);
		hop_res_t res;
		int n, ev, s, base, nfree, pick;
		longint unsigned tot, r, target, acc, inc, sum;
		res = '{default: 0};
		n = (active_parts > SLOTS) ? SLOTS : active_parts;
		ev = 0;
		tot = 0;
		for (int p = 0; p < n; p++) begin
			if (!part_on[p]) continue;
			s = part_site[p];
			base = s * DEGMAX;
			nfree = 0;
			for (int j = 0; j < site_degree[s]; j++)
				if (link_free(base + j)) nfree++;
			for (int j = 0; j < site_degree[s]; j++) begin
				if (!link_free(base + j) || ev >= DEPTH) continue;
				r = (longint'(link_rate[base + j]) << FRAC_BITS) / nfree;
				hop_rate[ev] = 40'(r);
				hop_part[ev] = 6'(p);
				hop_dst[ev] = link_site[base + j];
				ev++;
				tot += r;
				if (tot > 64'h1_FFFF_FFFF_FFFF) tot = 64'h1_FFFF_FFFF_FFFF;
			end
		end
		res.events = 10'(ev);
		res.total = 49'(tot);
		if (ev == 0 || tot == 0) begin
			res.status = STATUS_NOHOP;
			return res;
		end
		target = longint'(rnd) * (tot >> 32) + ((longint'(rnd) * (tot & 32'hFFFF_FFFF)) >> 32);
		acc = 0;
		pick = ev - 1;
		for (int i = 0; i < ev; i++) begin
			acc += hop_rate[i];
			if (acc > target) begin
				pick = i;
				break;
			end
		end
		inc = (64'd1 << 40) / tot;
		sum = sim_clock + inc;
		sim_clock = (sum < sim_clock) ? 64'hFFFF_FFFF_FFFF_FFFF : sum;
		res.status = STATUS_DONE;
		res.mover = hop_part[pick];
		res.src = part_site[hop_part[pick]];
		res.dst = hop_dst[pick];
		site_taken[res.src] = 1'b0;
		site_taken[res.dst] = 1'b1;
		part_site[hop_part[pick]] = res.dst;
		return res;
	endfunction

	// apply one command to the model, return its result
	function automatic hop_res_t predict_command(hop_cmd_t c);
		hop_res_t res;
		int idx;
		res = '{default: 0};
		idx = c.site * DEGMAX + c.slot;
		case (c.cmd)
			CMD_CLEAR: begin
				site_taken = '{default: 0};
				part_on = '{default: 0};
			end
			CMD_ADJ: begin
				link_site[idx] = c.nb;
				link_rate[idx] = c.rate;
				link_loaded[idx] = 1'b1;
			end
			CMD_DEG: site_degree[c.site] = (c.cnt > DEGMAX) ? 4'(DEGMAX) : c.cnt;
			CMD_PLACE: begin
				if (site_taken[c.site]) begin
					res.status = STATUS_REJECT;
				end else begin
					if (part_on[c.pidx]) site_taken[part_site[c.pidx]] = 1'b0;
					site_taken[c.site] = 1'b1;
					part_site[c.pidx] = c.site;
					part_on[c.pidx] = 1'b1;
				end
			end
			CMD_STEP: res = predict_hop(c.rnd);
			default: ;
		endcase
		res.elapsed = sim_clock;
		return res;
	endfunction

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		$display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	// result monitor
	always @(posedge clk) begin
		hop_res_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with no command outstanding", $realtime);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status) report_mismatch("status", status, want.status);
				if (moved_particle !== want.mover)
					report_mismatch("moved_particle", moved_particle, want.mover);
				if (from_site !== want.src) report_mismatch("from_site", from_site, want.src);
				if (to_site !== want.dst) report_mismatch("to_site", to_site, want.dst);
				if (event_total !== want.events)
					report_mismatch("event_total", event_total, want.events);
				if (total_rate !== want.total)
					report_mismatch("total_rate", total_rate, want.total);
				if (elapsed_time !== want.elapsed)
					report_mismatch("elapsed_time", elapsed_time, want.elapsed);
			end
		end
	end

	// drive one item, wait for acceptance, log its prediction
	task automatic send_item(hop_cmd_t c);
		int gap;
		gap = idle_gaps ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		command <= c.cmd;
		site_index <= c.site;
		slot_index <= c.slot;
		neighbor_index <= c.nb;
		path_rate <= c.rate;
		count_value <= c.cnt;
		particle_index <= c.pidx;
		random_fraction <= c.rnd;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		pending_results.push_back(predict_command(c));
		@(negedge clk);
	endtask

	// random field fill, so unused fields toggle too
	function automatic hop_cmd_t noise_item(bit [2:0] cmd);
		hop_cmd_t c;
		c.cmd = cmd;
		c.site = 10'($urandom);
		c.slot = 3'($urandom);
		c.nb = 10'($urandom);
		c.rate = $urandom;
		c.cnt = 4'($urandom);
		c.pidx = 6'($urandom);
		c.rnd = $urandom;
		return c;
	endfunction

	function automatic bit [9:0] pick_site();
		if ($urandom_range(0, 9) != 0) return 10'($urandom_range(0, 40));
		return 10'($urandom_range(980, 1023));
	endfunction

	task automatic send_link(bit [9:0] s, bit [2:0] k, bit [9:0] nb, bit [31:0] rate);
		hop_cmd_t c;
		c = noise_item(CMD_ADJ);
		c.site = s;
		c.slot = k;
		c.nb = nb;
		c.rate = rate;
		send_item(c);
	endtask

	// degree write; slots below it are loaded first so none is read unwritten
	task automatic send_degree(bit [9:0] s, bit [3:0] cnt);
		hop_cmd_t c;
		int eff;
		eff = (cnt > DEGMAX) ? DEGMAX : cnt;
		for (int j = 0; j < eff; j++)
			if (!link_loaded[s * DEGMAX + j])
				send_link(s, 3'(j), ($urandom_range(0, 7) == 0) ? 10'($urandom) : pick_site(),
					$urandom);
		c = noise_item(CMD_DEG);
		c.site = s;
		c.cnt = cnt;
		send_item(c);
	endtask

	task automatic send_place(bit [5:0] p, bit [9:0] s);
		hop_cmd_t c;
		c = noise_item(CMD_PLACE);
		c.pidx = p;
		c.site = s;
		send_item(c);
	endtask

	task automatic send_step(bit [31:0] rnd);
		hop_cmd_t c;
		c = noise_item(CMD_STEP);
		c.rnd = rnd;
		send_item(c);
	endtask

	// wait until the block is idle, then write particle_count
	task automatic write_particle_count(bit [6:0] value);
		start <= 1'b0;
		wait (pending_results.size() == 0);
		@(negedge clk);
		while (busy) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		active_parts = value;
	endtask

	// corner cases: empty step, rejections, zero rates, extremes
	task automatic test_directed();
		hop_cmd_t c;
		send_item(noise_item(CMD_CLEAR));
		send_step(32'h0);
		send_link(10'd0, 3'd0, 10'd1, 32'hFFFF_FFFF);
		send_link(10'd0, 3'd1, 10'd1023, 32'h0);
		send_degree(10'd0, 4'd2);
		send_place(6'd0, 10'd0);
		send_place(6'd1, 10'd0);
		send_place(6'd0, 10'd0);
		send_step(32'h0);
		send_step(32'hFFFF_FFFF);
		send_degree(10'd1023, 4'd15);
		send_place(6'd63, 10'd1023);
		send_step(32'h8000_0000);
		c = noise_item(3'd7);
		send_item(c);
		send_item(noise_item(3'd5));
		send_item(noise_item(3'd6));
		send_item(noise_item(CMD_CLEAR));
		// zero total: one listed hop with path rate zero
		send_link(10'd1, 3'd0, 10'd2, 32'h0);
		send_degree(10'd1, 4'd1);
		send_place(6'd2, 10'd1);
		send_step($urandom);
		// re-placement frees the old site
		send_place(6'd2, 10'd0);
		send_place(6'd3, 10'd1);
		send_step($urandom);
	endtask

	// mostly well-formed streams of steps, places, links, degrees and clears, some noise
	task automatic test_random(int count);
		int w;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 29) == 0) idle_gaps = !idle_gaps;
			w = $urandom_range(0, 99);
			if (w < 35) send_step($urandom);
			else if (w < 65)
				send_place(($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 15)),
					pick_site());
			else if (w < 78)
				send_link(pick_site(), 3'($urandom), ($urandom_range(0, 7) == 0) ? 10'($urandom) :
					pick_site(), $urandom);
			else if (w < 90) send_degree(pick_site(), 4'($urandom));
			else if (w < 93) send_item(noise_item(CMD_CLEAR));
			else send_item(noise_item(3'($urandom_range(5, 7))));
		end
	endtask

	initial begin
		site_taken = '{default: 0};
		site_degree = '{default: 0};
		link_site = '{default: 0};
		link_rate = '{default: 0};
		link_loaded = '{default: 0};
		part_site = '{default: 0};
		part_on = '{default: 0};
		sim_clock = 0;
		active_parts = 7'd50;
		mismatches = 0;
		idle_gaps = 1'b1;
		arst_n = 1'b0;
		start = 1'b0;
		command = CMD_CLEAR;
		site_index = '0;
		slot_index = '0;
		neighbor_index = '0;
		path_rate = '0;
		count_value = '0;
		particle_index = '0;
		random_fraction = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random(80);
		write_particle_count(7'd64);
		test_random(90);
		write_particle_count(7'd0);
		test_random(30);
		write_particle_count(7'd127);
		test_random(80);
		write_particle_count(7'($urandom_range(1, 63)));
		test_random(80);

		start <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (50) @(negedge clk);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// watchdog
	initial begin
		#500_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/lhes_pkg.sv
rtl/lhes_ram.sv
rtl/lhes_divider.sv
rtl/lattice_hop_event_selector_top.sv
sim/tb_lattice_hop_event_selector_top.sv
